// ----- hw/rtl/eth_ipv4_tcp_udp_header_parser_top_macros.svh -----
// Assertion macros for the header parser.
// Each check is sampled on the rising edge of clk_i and is off while rst_ni is low.
`ifndef ETH_IPV4_TCP_UDP_HEADER_PARSER_TOP_MACROS_SVH
`define ETH_IPV4_TCP_UDP_HEADER_PARSER_TOP_MACROS_SVH

// General property check.
`define ETHP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Overlapping implication check.
`define ETHP_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check.
`define ETHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ethp_pkg.sv -----
package ethp_pkg;

  // Header sizes and field codes.
  localparam logic [7:0]  EthHdrLen  = 8'd14;
  localparam logic [7:0]  IpMinLen   = 8'd20;
  localparam logic [7:0]  TcpMinLen  = 8'd20;
  localparam logic [7:0]  UdpHdrLen  = 8'd8;
  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [3:0]  IpVersion4 = 4'd4;
  localparam logic [7:0]  ProtoTcp   = 8'd6;
  localparam logic [7:0]  ProtoUdp   = 8'd17;
  localparam int unsigned TpBytes    = 14;

  // Bit positions in the layer mask.
  localparam int unsigned LayerEth  = 0;
  localparam int unsigned LayerIpv4 = 1;
  localparam int unsigned LayerTcp  = 2;
  localparam int unsigned LayerUdp  = 3;

  typedef enum logic [3:0] {
    ANOM_NONE        = 4'd0,
    ANOM_SHORT_ETH   = 4'd1,
    ANOM_SHORT_IP    = 4'd2,
    ANOM_BAD_IP_HDR  = 4'd3,
    ANOM_BAD_TOTAL   = 4'd4,
    ANOM_SHORT_TCP   = 4'd5,
    ANOM_BAD_TCP_HDR = 4'd6,
    ANOM_BAD_UDP_LEN = 4'd7,
    ANOM_UDP_MISMATCH = 4'd8,
    ANOM_SHORT_UDP   = 4'd9
  } anomaly_e;

  // One input item.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       byte_present;
    logic       end_of_frame;
  } byte_item_t;

  // Header fields latched during a frame.
  typedef struct packed {
    logic [15:0]              eth_type;
    logic [7:0]               version_ihl;
    logic [15:0]              total_length;
    logic [7:0]               protocol;
    logic [31:0]              src_addr;
    logic [31:0]              dst_addr;
    logic [TpBytes-1:0][7:0]  tp_bytes;
  } frame_fields_t;

  // One result item.
  typedef struct packed {
    logic [3:0]  layers_found;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [23:0] ip_lengths;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [31:0] port_pair;
    logic [63:0] seq_and_ack;
    logic [15:0] l4_detail;
    logic [7:0]  payload_offset;
    logic [15:0] payload_length;
    anomaly_e    anomaly;
  } result_t;

endpackage

// ----- hw/rtl/ethp_byte_if.sv -----
interface ethp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       byte_present;
  logic       end_of_frame;

  modport source (output valid, frame_byte, byte_present, end_of_frame, input ready);
  modport sink (input valid, frame_byte, byte_present, end_of_frame, output ready);
endinterface

// ----- hw/rtl/ethp_result_if.sv -----
interface ethp_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  layers_found;
  logic [15:0] ether_type;
  logic [7:0]  ip_protocol;
  logic [23:0] ip_lengths;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [31:0] port_pair;
  logic [63:0] seq_and_ack;
  logic [15:0] l4_detail;
  logic [7:0]  payload_offset;
  logic [15:0] payload_length;
  logic [3:0]  anomaly;

  modport source (
    output valid, layers_found, ether_type, ip_protocol, ip_lengths, source_address,
           dest_address, port_pair, seq_and_ack, l4_detail, payload_offset,
           payload_length, anomaly,
    input  ready
  );
  modport sink (
    input  valid, layers_found, ether_type, ip_protocol, ip_lengths, source_address,
           dest_address, port_pair, seq_and_ack, l4_detail, payload_offset,
           payload_length, anomaly,
    output ready
  );
endinterface

// ----- hw/rtl/ethp_frame_state.sv -----
module ethp_frame_state #(
  parameter int unsigned CountBits = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  ethp_pkg::byte_item_t   item_i,
  output logic [CountBits-1:0]   count_next_o,
  output ethp_pkg::frame_fields_t fields_next_o
);

  localparam int unsigned W = (CountBits > 16) ? CountBits : 16;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  logic [CountBits-1:0]    count_q, count_d;
  ethp_pkg::frame_fields_t fields_q, fields_d;
  logic [W-1:0]            off_w;
  logic [W-1:0]            tstart_w;
  logic [7:0]              ihl_cur;
  logic                    take;
  logic                    tp_hit;
  logic [3:0]              tp_idx;

  // Offset of this byte and start of the transport header.
  assign off_w    = W'(count_q);
  assign ihl_cur  = {2'b00, fields_q.version_ihl[3:0], 2'b00};
  assign tstart_w = W'(ethp_pkg::EthHdrLen) + W'(ihl_cur);
  assign take     = item_i.byte_present && (count_q != CountMax);
  assign tp_hit   = (off_w >= W'(34)) && (off_w >= tstart_w)
                 && (off_w < tstart_w + W'(ethp_pkg::TpBytes));
  assign tp_idx   = 4'(off_w - tstart_w);

  // Latch the byte into whichever field its offset selects.
  always_comb begin
    fields_d = fields_q;
    count_d  = count_q;
    if (take) begin
      count_d = count_q + 1'b1;
      if (off_w == W'(12)) begin
        fields_d.eth_type[15:8] = item_i.frame_byte;
      end else if (off_w == W'(13)) begin
        fields_d.eth_type[7:0] = item_i.frame_byte;
      end else if (off_w == W'(14)) begin
        fields_d.version_ihl = item_i.frame_byte;
      end else if (off_w == W'(16)) begin
        fields_d.total_length[15:8] = item_i.frame_byte;
      end else if (off_w == W'(17)) begin
        fields_d.total_length[7:0] = item_i.frame_byte;
      end else if (off_w == W'(23)) begin
        fields_d.protocol = item_i.frame_byte;
      end else if (off_w >= W'(26) && off_w <= W'(29)) begin
        fields_d.src_addr = {fields_q.src_addr[23:0], item_i.frame_byte};
      end else if (off_w >= W'(30) && off_w <= W'(33)) begin
        fields_d.dst_addr = {fields_q.dst_addr[23:0], item_i.frame_byte};
      end
      if (tp_hit) begin
        fields_d.tp_bytes[tp_idx] = item_i.frame_byte;
      end
    end
  end

  assign count_next_o  = count_d;
  assign fields_next_o = fields_d;

  // Per-frame state; the end of a frame clears it for the next one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      fields_q <= '0;
    end else if (step_i) begin
      if (item_i.end_of_frame) begin
        count_q  <= '0;
        fields_q <= '0;
      end else begin
        count_q  <= count_d;
        fields_q <= fields_d;
      end
    end
  end

endmodule

// ----- hw/rtl/ethp_result_calc.sv -----
module ethp_result_calc #(
  parameter int unsigned CountBits = 16
) (
  input  logic [CountBits-1:0]    count_i,
  input  ethp_pkg::frame_fields_t fields_i,
  output ethp_pkg::result_t       result_o
);

  localparam int unsigned W = (CountBits > 16) ? CountBits : 16;

  logic [W-1:0]  cap_w;
  logic [W-1:0]  avail_w;
  logic [3:0]    version;
  logic [7:0]    ihl;
  logic [15:0]   total;
  logic [15:0]   ipcap;
  logic [15:0]   l4;
  logic [7:0]    thdr;
  logic [15:0]   ulen;
  logic [31:0]   ports;

  // Lengths derived from the captured count and the IPv4 header.
  assign cap_w   = W'(count_i);
  assign avail_w = cap_w - W'(ethp_pkg::EthHdrLen);
  assign version = fields_i.version_ihl[7:4];
  assign ihl     = {2'b00, fields_i.version_ihl[3:0], 2'b00};
  assign total   = fields_i.total_length;
  assign ipcap   = (W'(total) <= avail_w) ? total : avail_w[15:0];
  assign l4      = ipcap - {8'h00, ihl};
  assign thdr    = {2'b00, fields_i.tp_bytes[12][7:4], 2'b00};
  assign ulen    = {fields_i.tp_bytes[4], fields_i.tp_bytes[5]};
  assign ports   = {fields_i.tp_bytes[0], fields_i.tp_bytes[1],
                    fields_i.tp_bytes[2], fields_i.tp_bytes[3]};

  // Layer checks in priority order; the first failing check sets the anomaly.
  always_comb begin
    result_o         = '0;
    result_o.anomaly = ethp_pkg::ANOM_NONE;
    if (cap_w < W'(ethp_pkg::EthHdrLen)) begin
      result_o.anomaly = ethp_pkg::ANOM_SHORT_ETH;
    end else begin
      result_o.layers_found[ethp_pkg::LayerEth] = 1'b1;
      result_o.ether_type = fields_i.eth_type;
      if (fields_i.eth_type == ethp_pkg::EtherTypeIpv4) begin
        if (cap_w < W'(ethp_pkg::EthHdrLen) + W'(ethp_pkg::IpMinLen)) begin
          result_o.anomaly = ethp_pkg::ANOM_SHORT_IP;
        end else if (version != ethp_pkg::IpVersion4 || ihl < ethp_pkg::IpMinLen) begin
          result_o.anomaly = ethp_pkg::ANOM_BAD_IP_HDR;
        end else if (cap_w < W'(ethp_pkg::EthHdrLen) + W'(ihl)) begin
          result_o.anomaly = ethp_pkg::ANOM_SHORT_IP;
        end else if (total < {8'h00, ihl}) begin
          result_o.anomaly = ethp_pkg::ANOM_BAD_TOTAL;
        end else begin
          result_o.layers_found[ethp_pkg::LayerIpv4] = 1'b1;
          result_o.ip_protocol    = fields_i.protocol;
          result_o.ip_lengths     = {ihl, total};
          result_o.source_address = fields_i.src_addr;
          result_o.dest_address   = fields_i.dst_addr;
          if (fields_i.protocol == ethp_pkg::ProtoTcp) begin
            if (l4 < 16'(ethp_pkg::TcpMinLen)) begin
              result_o.anomaly = ethp_pkg::ANOM_SHORT_TCP;
            end else if (thdr < ethp_pkg::TcpMinLen) begin
              result_o.anomaly = ethp_pkg::ANOM_BAD_TCP_HDR;
            end else if (l4 < {8'h00, thdr}) begin
              result_o.anomaly = ethp_pkg::ANOM_SHORT_TCP;
            end else begin
              result_o.layers_found[ethp_pkg::LayerTcp] = 1'b1;
              result_o.port_pair   = ports;
              result_o.seq_and_ack = {fields_i.tp_bytes[4], fields_i.tp_bytes[5],
                                      fields_i.tp_bytes[6], fields_i.tp_bytes[7],
                                      fields_i.tp_bytes[8], fields_i.tp_bytes[9],
                                      fields_i.tp_bytes[10], fields_i.tp_bytes[11]};
              result_o.l4_detail      = {thdr, fields_i.tp_bytes[13]};
              result_o.payload_offset = ethp_pkg::EthHdrLen + ihl + thdr;
              result_o.payload_length = l4 - {8'h00, thdr};
            end
          end else if (fields_i.protocol == ethp_pkg::ProtoUdp) begin
            if (l4 < 16'(ethp_pkg::UdpHdrLen)) begin
              result_o.anomaly = ethp_pkg::ANOM_SHORT_UDP;
            end else if (ulen < 16'(ethp_pkg::UdpHdrLen)) begin
              result_o.anomaly = ethp_pkg::ANOM_BAD_UDP_LEN;
            end else begin
              // The layer is reported even when the length field disagrees.
              if (ulen < l4) begin
                result_o.anomaly = ethp_pkg::ANOM_UDP_MISMATCH;
              end else if (ulen > l4) begin
                result_o.anomaly = ethp_pkg::ANOM_SHORT_UDP;
              end
              result_o.layers_found[ethp_pkg::LayerUdp] = 1'b1;
              result_o.port_pair      = ports;
              result_o.l4_detail      = ulen;
              result_o.payload_offset = ethp_pkg::EthHdrLen + ihl + ethp_pkg::UdpHdrLen;
              result_o.payload_length = l4 - 16'(ethp_pkg::UdpHdrLen);
            end
          end
        end
      end
    end
  end

endmodule

// ----- hw/rtl/eth_ipv4_tcp_udp_header_parser_top.sv -----
// Ethernet II / IPv4 / TCP / UDP header parser.
// byte_i carries one captured frame byte per transfer in wire order. byte_present
// low marks an item with no byte (an empty end marker, or an idle item when
// end_of_frame is also low). end_of_frame marks the last item of a frame.
// result_o carries one transfer per frame: the layers found, the header fields,
// the payload offset and captured payload length, and an anomaly code.
// Throughput is one input item per cycle while byte_i.ready is high, held by the
// single-pass update of the latched header registers between the input register
// and the result register. The result register loads when the end-of-frame item
// leaves the input register. The byte count saturates at 2**COUNT_BITS-1; bytes
// past that are ignored. Reset clears the stage valid flags and all per-frame state.
// When the receiver stalls, the result is held and bytes keep flowing until an
// end-of-frame item reaches the input register; byte_i.ready then drops until
// the held result is taken.
`include "eth_ipv4_tcp_udp_header_parser_top_macros.svh"

module eth_ipv4_tcp_udp_header_parser_top #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ethp_byte_if.sink     byte_i,
  ethp_result_if.source result_o
);

  ethp_pkg::byte_item_t    in_q;
  logic                    in_valid_q;
  logic                    stall;
  logic                    advance;
  logic                    out_load;
  logic                    out_valid_q;
  ethp_pkg::result_t       out_q;
  ethp_pkg::result_t       result_d;
  logic [COUNT_BITS-1:0]   count_next;
  ethp_pkg::frame_fields_t fields_next;

  // An end-of-frame item waits while the result register is still full.
  assign stall    = in_valid_q && in_q.end_of_frame && out_valid_q && !result_o.ready;
  assign advance  = in_valid_q && !stall;
  assign out_load = advance && in_q.end_of_frame;
  assign byte_i.ready = !in_valid_q || !stall;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.valid && byte_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_q.frame_byte   <= byte_i.frame_byte;
      in_q.byte_present <= byte_i.byte_present;
      in_q.end_of_frame <= byte_i.end_of_frame;
    end
  end

  // Per-frame byte count and latched header fields.
  ethp_frame_state #(
    .CountBits (COUNT_BITS)
  ) u_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .item_i        (in_q),
    .count_next_o  (count_next),
    .fields_next_o (fields_next)
  );

  // Result fields from the state as it stands after the last byte.
  ethp_result_calc #(
    .CountBits (COUNT_BITS)
  ) u_calc (
    .count_i  (count_next),
    .fields_i (fields_next),
    .result_o (result_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= result_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.layers_found   = out_q.layers_found;
  assign result_o.ether_type     = out_q.ether_type;
  assign result_o.ip_protocol    = out_q.ip_protocol;
  assign result_o.ip_lengths     = out_q.ip_lengths;
  assign result_o.source_address = out_q.source_address;
  assign result_o.dest_address   = out_q.dest_address;
  assign result_o.port_pair      = out_q.port_pair;
  assign result_o.seq_and_ack    = out_q.seq_and_ack;
  assign result_o.l4_detail      = out_q.l4_detail;
  assign result_o.payload_offset = out_q.payload_offset;
  assign result_o.payload_length = out_q.payload_length;
  assign result_o.anomaly        = out_q.anomaly;

  // A new result only ever comes from an end-of-frame item.
  `ETHP_ASSERT_IMPLIES(a_result_from_eof, $rose(result_o.valid),
    $past(in_valid_q && in_q.end_of_frame), "result appeared without an end-of-frame item")

  // A frame end restarts the byte count.
  `ETHP_ASSERT_NEXT(a_count_restart, out_load && in_q.byte_present,
    u_state.count_q == '0, "byte count not cleared after frame end")

  // A TCP layer sits on IPv4 over Ethernet, excludes UDP and is clean.
  `ETHP_ASSERT_IMPLIES(a_tcp_layers, result_o.valid && result_o.layers_found[ethp_pkg::LayerTcp],
    result_o.layers_found[ethp_pkg::LayerIpv4] && result_o.layers_found[ethp_pkg::LayerEth]
    && !result_o.layers_found[ethp_pkg::LayerUdp] && result_o.anomaly == ethp_pkg::ANOM_NONE,
    "inconsistent TCP layer report")

  // A short Ethernet capture reports no layer at all.
  `ETHP_ASSERT_IMPLIES(a_short_eth, result_o.valid
    && result_o.anomaly == ethp_pkg::ANOM_SHORT_ETH, result_o.layers_found == 4'h0,
    "layers reported on a short Ethernet capture")

endmodule

// ----- sim/eth_ipv4_tcp_udp_header_parser_top_tb.sv -----
`timescale 1ns / 100ps

module eth_ipv4_tcp_udp_header_parser_top_tb;

  localparam int unsigned CountBits = 16;
  localparam int unsigned CountMax  = (1 << CountBits) - 1;

  // Header sizes as plain integers for the length arithmetic.
  localparam int unsigned EthHdr = ethp_pkg::EthHdrLen;
  localparam int unsigned IpMin  = ethp_pkg::IpMinLen;
  localparam int unsigned TcpMin = ethp_pkg::TcpMinLen;
  localparam int unsigned UdpHdr = ethp_pkg::UdpHdrLen;

  logic clk_i;
  logic rst_ni;

  ethp_byte_if   byte_bus ();
  ethp_result_if result_bus ();

  eth_ipv4_tcp_udp_header_parser_top #(
    .COUNT_BITS(CountBits)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_bus),
    .result_o(result_bus)
  );

  // Frame tracking state, mirrored from the bytes the parser accepts.
  int unsigned             byte_count;
  ethp_pkg::frame_fields_t hdr_seen;
  ethp_pkg::result_t       reports_due[$];

  logic [7:0] frame_buf[$];
  int         error_count;
  int         bytes_sent;
  bit         calm;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // The run ends here if the parser stops making progress.
  initial begin
    #8_000_000;
    $display("[eth_ipv4_tcp_udp_header_parser_top] ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      report_mismatch($sformatf("%s: expected %0h, got %0h", name, want, got));
    end
  endtask

  function automatic int draw_gap();
    return calm ? 0 : int'($urandom_range(0, 5));
  endfunction

  function automatic void clear_frame_state();
    byte_count = 0;
    hdr_seen   = '0;
  endfunction

  // Capture the header bytes at their fixed offsets; the transport bytes follow
  // wherever the IHL latched so far places the end of the IP header.
  function automatic void latch_header_byte(input int unsigned off, input logic [7:0] b);
    int unsigned l4_start;
    l4_start = EthHdr + 4 * hdr_seen.version_ihl[3:0];
    if (off == 12) hdr_seen.eth_type[15:8] = b;
    else if (off == 13) hdr_seen.eth_type[7:0] = b;
    else if (off == 14) hdr_seen.version_ihl = b;
    else if (off == 16) hdr_seen.total_length[15:8] = b;
    else if (off == 17) hdr_seen.total_length[7:0] = b;
    else if (off == 23) hdr_seen.protocol = b;
    else if (off >= 26 && off <= 29) hdr_seen.src_addr = {hdr_seen.src_addr[23:0], b};
    else if (off >= 30 && off <= 33) hdr_seen.dst_addr = {hdr_seen.dst_addr[23:0], b};
    if (off >= 34 && off >= l4_start && off < l4_start + ethp_pkg::TpBytes) begin
      hdr_seen.tp_bytes[off - l4_start] = b;
    end
  endfunction

  // Work out the per-frame summary from the latched fields and the byte count.
  function automatic ethp_pkg::result_t parse_frame_headers();
    ethp_pkg::result_t                 r;
    logic [ethp_pkg::TpBytes-1:0][7:0] tp;
    int unsigned                       caplen, ihl, total, ipcap, l4, thdr, ulen;
    r        = '0;
    r.anomaly = ethp_pkg::ANOM_NONE;
    tp       = hdr_seen.tp_bytes;
    caplen   = byte_count;
    if (caplen < EthHdr) begin
      r.anomaly = ethp_pkg::ANOM_SHORT_ETH;
      return r;
    end
    r.layers_found[ethp_pkg::LayerEth] = 1'b1;
    r.ether_type = hdr_seen.eth_type;
    if (hdr_seen.eth_type != ethp_pkg::EtherTypeIpv4) return r;

    ihl   = 4 * hdr_seen.version_ihl[3:0];
    total = {16'd0, hdr_seen.total_length};
    if (caplen < EthHdr + IpMin) r.anomaly = ethp_pkg::ANOM_SHORT_IP;
    else if (hdr_seen.version_ihl[7:4] != ethp_pkg::IpVersion4 || ihl < IpMin) begin
      r.anomaly = ethp_pkg::ANOM_BAD_IP_HDR;
    end else if (caplen < EthHdr + ihl) r.anomaly = ethp_pkg::ANOM_SHORT_IP;
    else if (total < ihl) r.anomaly = ethp_pkg::ANOM_BAD_TOTAL;
    else begin
      // The datagram ends at the total length or at the end of the capture.
      ipcap = (total <= caplen - EthHdr) ? total : caplen - EthHdr;
      l4    = ipcap - ihl;
      r.layers_found[ethp_pkg::LayerIpv4] = 1'b1;
      r.ip_protocol    = hdr_seen.protocol;
      r.ip_lengths     = {8'(ihl), 16'(total)};
      r.source_address = hdr_seen.src_addr;
      r.dest_address   = hdr_seen.dst_addr;
      if (hdr_seen.protocol == ethp_pkg::ProtoTcp) begin
        thdr = 4 * tp[12][7:4];
        if (l4 < TcpMin) r.anomaly = ethp_pkg::ANOM_SHORT_TCP;
        else if (thdr < TcpMin) r.anomaly = ethp_pkg::ANOM_BAD_TCP_HDR;
        else if (l4 < thdr) r.anomaly = ethp_pkg::ANOM_SHORT_TCP;
        else begin
          r.layers_found[ethp_pkg::LayerTcp] = 1'b1;
          r.port_pair      = {tp[0], tp[1], tp[2], tp[3]};
          r.seq_and_ack    = {tp[4], tp[5], tp[6], tp[7], tp[8], tp[9], tp[10], tp[11]};
          r.l4_detail      = {8'(thdr), tp[13]};
          r.payload_offset = 8'(EthHdr + ihl + thdr);
          r.payload_length = 16'(l4 - thdr);
        end
      end else if (hdr_seen.protocol == ethp_pkg::ProtoUdp) begin
        ulen = {16'd0, tp[4], tp[5]};
        if (l4 < UdpHdr) r.anomaly = ethp_pkg::ANOM_SHORT_UDP;
        else if (ulen < UdpHdr) r.anomaly = ethp_pkg::ANOM_BAD_UDP_LEN;
        else begin
          // A length field that disagrees with the datagram still reports the layer.
          if (ulen < l4) r.anomaly = ethp_pkg::ANOM_UDP_MISMATCH;
          else if (ulen > l4) r.anomaly = ethp_pkg::ANOM_SHORT_UDP;
          r.layers_found[ethp_pkg::LayerUdp] = 1'b1;
          r.port_pair      = {tp[0], tp[1], tp[2], tp[3]};
          r.l4_detail      = 16'(ulen);
          r.payload_offset = 8'(EthHdr + ihl + UdpHdr);
          r.payload_length = 16'(l4 - UdpHdr);
        end
      end
    end
    return r;
  endfunction

  function automatic void track_frame_byte(input ethp_pkg::byte_item_t it);
    if (it.byte_present && byte_count < CountMax) begin
      latch_header_byte(byte_count, it.frame_byte);
      byte_count++;
    end
    if (it.end_of_frame) begin
      reports_due.push_back(parse_frame_headers());
      clear_frame_state();
    end
  endfunction

  // Offer one item after a random gap and hold it until the parser takes it.
  task automatic send_item(input ethp_pkg::byte_item_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      byte_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_bus.valid        <= 1'b1;
    byte_bus.frame_byte   <= it.frame_byte;
    byte_bus.byte_present <= it.byte_present;
    byte_bus.end_of_frame <= it.end_of_frame;
    do @(posedge clk_i); while (!byte_bus.ready);
    track_frame_byte(it);
    if (it.byte_present) bytes_sent++;
  endtask

  task automatic send_idle();
    ethp_pkg::byte_item_t it;
    it.frame_byte   = 8'($urandom);
    it.byte_present = 1'b0;
    it.end_of_frame = 1'b0;
    send_item(it);
  endtask

  // Send frame_buf, closing it on the last byte or with an empty marker.
  task automatic send_frame(input bit end_by_marker, input bit no_gaps);
    ethp_pkg::byte_item_t it;
    int                   idx;
    calm = no_gaps || ($urandom_range(0, 4) == 0);
    for (idx = 0; idx < frame_buf.size(); idx++) begin
      if (!calm && $urandom_range(0, 15) == 0) send_idle();
      it.frame_byte   = frame_buf[idx];
      it.byte_present = 1'b1;
      it.end_of_frame = (idx == frame_buf.size() - 1) && !end_by_marker;
      send_item(it);
    end
    if (end_by_marker || frame_buf.size() == 0) begin
      it.frame_byte   = 8'($urandom);
      it.byte_present = 1'b0;
      it.end_of_frame = 1'b1;
      send_item(it);
    end
  endtask

  // Build a frame with random content around the given header choices. The
  // adjustments skew the IP total length and the UDP length field; cap >= 0
  // cuts the capture to at most that many bytes.
  task automatic build_frame(input logic [15:0] etype, input logic [7:0] ver_ihl,
                             input logic [7:0] proto, input logic [3:0] doff,
                             input int pay_len, input int total_adj, input int udp_adj,
                             input int trail, input int cap);
    int          ihl, l4_hdr;
    logic [15:0] total_f, ulen_f;
    frame_buf.delete();
    ihl = 4 * int'(ver_ihl[3:0]);
    if (proto == ethp_pkg::ProtoTcp) l4_hdr = 4 * int'(doff);
    else if (proto == ethp_pkg::ProtoUdp) l4_hdr = UdpHdr;
    else l4_hdr = 0;
    total_f = 16'(ihl + l4_hdr + pay_len + total_adj);
    ulen_f  = 16'(int'(UdpHdr) + pay_len + udp_adj);

    repeat (12) frame_buf.push_back(8'($urandom));
    frame_buf.push_back(etype[15:8]);
    frame_buf.push_back(etype[7:0]);
    frame_buf.push_back(ver_ihl);
    frame_buf.push_back(8'($urandom));
    frame_buf.push_back(total_f[15:8]);
    frame_buf.push_back(total_f[7:0]);
    repeat (5) frame_buf.push_back(8'($urandom));
    frame_buf.push_back(proto);
    repeat (10) frame_buf.push_back(8'($urandom));
    repeat ((ihl > 20) ? ihl - 20 : 0) frame_buf.push_back(8'($urandom));

    if (proto == ethp_pkg::ProtoTcp) begin
      repeat (12) frame_buf.push_back(8'($urandom));
      frame_buf.push_back({doff, 4'($urandom)});
      frame_buf.push_back(8'($urandom));
      repeat (((l4_hdr > 20) ? l4_hdr : 20) - 14) frame_buf.push_back(8'($urandom));
    end else if (proto == ethp_pkg::ProtoUdp) begin
      repeat (4) frame_buf.push_back(8'($urandom));
      frame_buf.push_back(ulen_f[15:8]);
      frame_buf.push_back(ulen_f[7:0]);
      repeat (2) frame_buf.push_back(8'($urandom));
    end
    repeat (pay_len + trail) frame_buf.push_back(8'($urandom));
    if (cap >= 0) begin
      while (frame_buf.size() > cap) void'(frame_buf.pop_back());
    end
  endtask

  task automatic test_short_captures();
    // A capture of length zero, a single byte, and one byte short of Ethernet.
    frame_buf.delete();
    send_frame(1'b1, 1'b0);
    frame_buf.push_back(8'hFF);
    send_frame(1'b0, 1'b0);
    frame_buf.delete();
    repeat (13) frame_buf.push_back(8'h00);
    send_frame(1'b0, 1'b0);
    // IPv4 captures cut at the start of or inside the IP header.
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h45, ethp_pkg::ProtoTcp, 4'd5, 0, 0, 0, 0, 14);
    send_frame(1'b0, 1'b0);
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h45, ethp_pkg::ProtoTcp, 4'd5, 0, 0, 0, 0, 33);
    send_frame(1'b0, 1'b0);
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h46, ethp_pkg::ProtoTcp, 4'd5, 0, 0, 0, 0, 37);
    send_frame(1'b0, 1'b0);
  endtask

  task automatic test_non_ipv4();
    logic [15:0] types[4];
    types = '{16'h86DD, 16'hFFFF, 16'h0000, 16'h0801};
    foreach (types[i]) begin
      build_frame(types[i], 8'h45, ethp_pkg::ProtoTcp, 4'd5, 8, 0, 0, 0, -1);
      send_frame(1'b0, 1'b0);
    end
    // Exactly an Ethernet header and nothing more.
    build_frame(16'h0806, 8'h45, ethp_pkg::ProtoTcp, 4'd5, 0, 0, 0, 0, 14);
    send_frame(1'b0, 1'b0);
  endtask

  task automatic test_ip_header_checks();
    logic [7:0] bad[4];
    bad = '{8'h65, 8'h44, 8'h00, 8'hF5};
    foreach (bad[i]) begin
      build_frame(ethp_pkg::EtherTypeIpv4, bad[i], ethp_pkg::ProtoTcp, 4'd5, 6, 0, 0, 0, -1);
      send_frame(1'b0, 1'b0);
    end
    // Total length below the header length, then equal to it.
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h45, ethp_pkg::ProtoTcp, 4'd5, 10, -31, 0, 0, -1);
    send_frame(1'b0, 1'b0);
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h45, ethp_pkg::ProtoTcp, 4'd5, 10, -30, 0, 0, -1);
    send_frame(1'b0, 1'b0);
    // Largest IP header, with Ethernet padding behind the datagram.
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h4F, ethp_pkg::ProtoTcp, 4'd5, 3, 0, 0, 10, -1);
    send_frame(1'b0, 1'b0);
  endtask

  task automatic test_tcp_segments();
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h45, ethp_pkg::ProtoTcp, 4'd5, 0, 0, 0, 0, -1);
    send_frame(1'b0, 1'b0);
    // Both headers at their largest put the payload at its furthest offset.
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h4F, ethp_pkg::ProtoTcp, 4'd15, 9, 0, 0, 0, -1);
    send_frame(1'b0, 1'b0);
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h45, ethp_pkg::ProtoTcp, 4'd4, 10, 0, 0, 0, -1);
    send_frame(1'b0, 1'b0);
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h45, ethp_pkg::ProtoTcp, 4'd8, 0, 0, 0, 0, 59);
    send_frame(1'b0, 1'b0);
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h45, ethp_pkg::ProtoTcp, 4'd5, 0, -5, 0, 0, -1);
    send_frame(1'b0, 1'b0);
    // Payload cut by the capture, padded after the datagram, and a long one.
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h45, ethp_pkg::ProtoTcp, 4'd5, 40, 0, 0, 0, 66);
    send_frame(1'b0, 1'b0);
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h45, ethp_pkg::ProtoTcp, 4'd5, 2, 0, 0, 6, -1);
    send_frame(1'b0, 1'b0);
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h45, ethp_pkg::ProtoTcp, 4'd5, 300, 0, 0, 0, -1);
    send_frame(1'b0, 1'b0);
  endtask

  task automatic test_udp_datagrams();
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h45, ethp_pkg::ProtoUdp, 4'd0, 12, 0, 0, 0, -1);
    send_frame(1'b0, 1'b0);
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h47, ethp_pkg::ProtoUdp, 4'd0, 0, 0, 0, 0, -1);
    send_frame(1'b0, 1'b0);
    // Length field below the UDP header.
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h45, ethp_pkg::ProtoUdp, 4'd0, 4, 0, -5, 0, -1);
    send_frame(1'b0, 1'b0);
    // Length field shorter, then longer, than the datagram carries.
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h45, ethp_pkg::ProtoUdp, 4'd0, 10, 0, -3, 0, -1);
    send_frame(1'b0, 1'b0);
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h45, ethp_pkg::ProtoUdp, 4'd0, 10, 0, 3, 0, -1);
    send_frame(1'b0, 1'b0);
    // Too little room for the UDP header.
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h45, ethp_pkg::ProtoUdp, 4'd0, 4, -7, 0, 0, -1);
    send_frame(1'b0, 1'b0);
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h45, ethp_pkg::ProtoUdp, 4'd0, 6, 0, 65521, 0, -1);
    send_frame(1'b0, 1'b0);
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h45, ethp_pkg::ProtoUdp, 4'd0, 30, 0, 0, 0, 52);
    send_frame(1'b0, 1'b0);
  endtask

  task automatic test_other_protocols();
    logic [7:0] protos[5];
    protos = '{8'd1, 8'd0, 8'hFF, 8'd16, 8'd18};
    foreach (protos[i]) begin
      build_frame(ethp_pkg::EtherTypeIpv4, 8'h45, protos[i], 4'd5, 20, 0, 0, 0, -1);
      send_frame(1'b0, 1'b0);
    end
  endtask

  task automatic test_idle_and_markers();
    ethp_pkg::byte_item_t it;
    repeat (3) send_idle();
    // An idle item ahead of every byte of a segment.
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h45, ethp_pkg::ProtoTcp, 4'd6, 5, 0, 0, 0, -1);
    foreach (frame_buf[i]) begin
      send_idle();
      it.frame_byte   = frame_buf[i];
      it.byte_present = 1'b1;
      it.end_of_frame = (i == frame_buf.size() - 1);
      send_item(it);
    end
    // A datagram closed by an empty marker, then two empty captures in a row.
    build_frame(ethp_pkg::EtherTypeIpv4, 8'h45, ethp_pkg::ProtoUdp, 4'd0, 7, 0, 0, 0, -1);
    send_frame(1'b1, 1'b0);
    frame_buf.delete();
    send_frame(1'b1, 1'b0);
    send_frame(1'b1, 1'b0);
  endtask

  task automatic test_random_traffic();
    int          frames, start_bytes, kind, pay, trail, cap, total_adj, udp_adj;
    bit          noise;
    logic [15:0] etype;
    logic [7:0]  ver_ihl, proto;
    logic [3:0]  doff;
    frames      = 0;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < 500 || frames < 8) begin
      kind      = $urandom_range(0, 99);
      etype     = ethp_pkg::EtherTypeIpv4;
      ver_ihl   = {ethp_pkg::IpVersion4,
                   ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5};
      doff      = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
      pay       = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
      trail     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      cap       = -1;
      total_adj = 0;
      udp_adj   = 0;
      noise     = 1'b0;
      if (kind < 45) proto = ethp_pkg::ProtoTcp;
      else if (kind < 75) proto = ethp_pkg::ProtoUdp;
      else proto = 8'($urandom);
      // Most frames are well formed; the rest get one field broken or are random bytes.
      if (kind >= 82) begin
        case ($urandom_range(0, 6))
          0: ver_ihl = 8'($urandom);
          1: total_adj = int'($urandom_range(0, 80)) - 60;
          2: udp_adj = int'($urandom_range(0, 20)) - 10;
          3: doff = 4'($urandom);
          4: cap = $urandom_range(0, 90);
          5: etype = 16'($urandom);
          default: noise = 1'b1;
        endcase
      end
      if (noise) begin
        frame_buf.delete();
        repeat ($urandom_range(0, 70)) frame_buf.push_back(8'($urandom));
      end else begin
        build_frame(etype, ver_ihl, proto, doff, pay, total_adj, udp_adj, trail, cap);
      end
      send_frame($urandom_range(0, 7) == 0, 1'b0);
      frames++;
    end
  endtask

  // Result receiver: may stall for a random gap before each transfer.
  initial begin : result_sink
    int gap;
    result_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        result_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!result_bus.valid);
    end
  end

  // Compare every result transfer against the oldest outstanding frame.
  always @(posedge clk_i) begin : check_results
    ethp_pkg::result_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (reports_due.size() == 0) begin
        report_mismatch("result transfer with no frame outstanding");
      end else begin
        want = reports_due.pop_front();
        check_field("layers_found", want.layers_found, result_bus.layers_found);
        check_field("ether_type", want.ether_type, result_bus.ether_type);
        check_field("ip_protocol", want.ip_protocol, result_bus.ip_protocol);
        check_field("ip_lengths", want.ip_lengths, result_bus.ip_lengths);
        check_field("source_address", want.source_address, result_bus.source_address);
        check_field("dest_address", want.dest_address, result_bus.dest_address);
        check_field("port_pair", want.port_pair, result_bus.port_pair);
        check_field("seq_and_ack", want.seq_and_ack, result_bus.seq_and_ack);
        check_field("l4_detail", want.l4_detail, result_bus.l4_detail);
        check_field("payload_offset", want.payload_offset, result_bus.payload_offset);
        check_field("payload_length", want.payload_length, result_bus.payload_length);
        check_field("anomaly", want.anomaly, result_bus.anomaly);
      end
    end
  end

  initial begin : run_tests
    error_count = 0;
    bytes_sent  = 0;
    calm        = 1'b0;
    clear_frame_state();
    rst_ni                <= 1'b0;
    byte_bus.valid        <= 1'b0;
    byte_bus.frame_byte   <= 8'h00;
    byte_bus.byte_present <= 1'b0;
    byte_bus.end_of_frame <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_short_captures();
    test_non_ipv4();
    test_ip_header_checks();
    test_tcp_segments();
    test_udp_datagrams();
    test_other_protocols();
    test_idle_and_markers();
    test_random_traffic();

    // Drain the outstanding results, then wait a margin before reporting.
    byte_bus.valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[eth_ipv4_tcp_udp_header_parser_top] OK");
    end else begin
      $display("[eth_ipv4_tcp_udp_header_parser_top] ERROR");
    end
    $finish;
  end

endmodule
